### sv/assert_macros.svh
// Assertion macros used by the checker of the circle clipping block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

### sv/scc_pkg.sv
// Widths, constants and pipeline payload types of the segment circle clipper.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  localparam int COORD_W  = 16;
  localparam int RAD_W    = COORD_W - 1;
  localparam int TOL_W    = 48;
  localparam logic [TOL_W-1:0] TOL_RESET = 48'd429497;

  // Squared length a and dot product h.
  localparam int A_W      = 34;
  // Quadratic term E = h*h - a*c.
  localparam int E_W      = 66;
  localparam int TERM_W   = E_W + 2;
  // Bits of floor(sqrt(E)).
  localparam int SQ_BITS  = 33;
  // Quotient bits of the rounding divider, offset by 2^(DIV_BITS-1).
  localparam int DIV_BITS = 17;
  localparam int NUM_W    = 52;
  localparam int DEN_W    = A_W + 1;
  localparam int LANES    = 4;

  // Payload through the square root stages.
  typedef struct packed {
    logic                      encl;
    logic                      miss;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic [A_W-1:0]            a;
    logic signed [A_W-1:0]     h;
    logic [E_W-1:0]            rem;
    logic [SQ_BITS-1:0]        root;
  } sq_t;

  // Payload through the divider stages, one lane per output coordinate.
  typedef struct packed {
    logic                                 encl;
    logic                                 miss;
    logic signed [COORD_W-1:0]            x1;
    logic signed [COORD_W-1:0]            y1;
    logic signed [COORD_W-1:0]            x2;
    logic signed [COORD_W-1:0]            y2;
    logic [DEN_W-1:0]                     den;
    logic [LANES-1:0][NUM_W-1:0]          rem;
    logic [LANES-1:0][DIV_BITS-1:0]       quo;
  } dv_t;

endpackage

`default_nettype wire

### sv/segment_circle_clip_top.sv
// Pipelined clipper of a segment against a circle centred at the origin.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  input   | in        | in_valid / in_stall  | start_x start_y end_x end_y radius
//  output  | out       | out_valid/ out_stall | inside_hit clip_start_x .. clip_end_y
//  config  | in        | disc_tolerance_we    | disc_tolerance_wdata
//
// One request enters per cycle while the output is not stalled; each passes 62 register stages.
// Most of the depth lies in the 33-stage bit-per-stage square root and the 17-stage divider.
// Synchronous reset clears every valid bit and loads the tolerance reset value.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module segment_circle_clip_top import scc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      disc_tolerance_we,
  input  wire logic [TOL_W-1:0]          disc_tolerance_wdata,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [COORD_W-1:0] start_x,
  input  wire logic signed [COORD_W-1:0] start_y,
  input  wire logic signed [COORD_W-1:0] end_x,
  input  wire logic signed [COORD_W-1:0] end_y,
  input  wire logic [RAD_W-1:0]          radius,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           inside_hit,
  output logic signed [COORD_W-1:0]      clip_start_x,
  output logic signed [COORD_W-1:0]      clip_start_y,
  output logic signed [COORD_W-1:0]      clip_end_x,
  output logic signed [COORD_W-1:0]      clip_end_y
);

  logic             en;
  logic [TOL_W-1:0] tol;

  // The pipeline advances unless a finished result is held back.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Graze tolerance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (disc_tolerance_we) begin
      tol <= disc_tolerance_wdata;
    end
  end

  // Stage A: capture the request.
  logic                      va;
  logic signed [COORD_W-1:0] a_x1, a_y1, a_x2, a_y2;
  logic [RAD_W-1:0]          a_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      a_x1 <= start_x;
      a_y1 <= start_y;
      a_x2 <= end_x;
      a_y2 <= end_y;
      a_r  <= radius;
    end
  end

  // Stage B: squares of the coordinates and radius, direction vector.
  logic signed [31:0]        m_sx1, m_sy1, m_sx2, m_sy2;
  logic [29:0]               m_rr;
  logic signed [16:0]        m_dx, m_dy;
  logic                      vb;
  logic [30:0]               b_sx1, b_sy1, b_sx2, b_sy2;
  logic [29:0]               b_rr;
  logic signed [16:0]        b_dx, b_dy;
  logic signed [COORD_W-1:0] b_x1, b_y1, b_x2, b_y2;

  assign m_sx1 = a_x1 * a_x1;
  assign m_sy1 = a_y1 * a_y1;
  assign m_sx2 = a_x2 * a_x2;
  assign m_sy2 = a_y2 * a_y2;
  assign m_rr  = a_r * a_r;
  assign m_dx  = a_x2 - a_x1;
  assign m_dy  = a_y2 - a_y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      b_sx1 <= m_sx1[30:0];
      b_sy1 <= m_sy1[30:0];
      b_sx2 <= m_sx2[30:0];
      b_sy2 <= m_sy2[30:0];
      b_rr  <= m_rr;
      b_dx  <= m_dx;
      b_dy  <= m_dy;
      b_x1  <= a_x1;
      b_y1  <= a_y1;
      b_x2  <= a_x2;
      b_y2  <= a_y2;
    end
  end

  // Stage C: inside test, c = |P1|^2 - R^2, partial products of a and h.
  logic [31:0]               m_p1sq, m_p2sq;
  logic signed [32:0]        m_c;
  logic signed [33:0]        m_ddx, m_ddy;
  logic signed [32:0]        m_hx, m_hy;
  logic                      vc;
  logic                      c_inside;
  logic signed [32:0]        c_c;
  logic [32:0]               c_ddx, c_ddy;
  logic signed [32:0]        c_hx, c_hy;
  logic signed [COORD_W-1:0] c_x1, c_y1, c_x2, c_y2;

  assign m_p1sq = {1'b0, b_sx1} + {1'b0, b_sy1};
  assign m_p2sq = {1'b0, b_sx2} + {1'b0, b_sy2};
  assign m_c    = $signed({1'b0, m_p1sq}) - $signed({3'b000, b_rr});
  assign m_ddx  = b_dx * b_dx;
  assign m_ddy  = b_dy * b_dy;
  assign m_hx   = b_x1 * b_dx;
  assign m_hy   = b_y1 * b_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
    if (en) begin
      c_inside <= (m_p1sq <= {2'b00, b_rr}) && (m_p2sq <= {2'b00, b_rr});
      c_c      <= m_c;
      c_ddx    <= m_ddx[32:0];
      c_ddy    <= m_ddy[32:0];
      c_hx     <= m_hx;
      c_hy     <= m_hy;
      c_x1     <= b_x1;
      c_y1     <= b_y1;
      c_x2     <= b_x2;
      c_y2     <= b_y2;
    end
  end

  // Stage D: a = |d|^2, h = P1.d, magnitude and sign of c.
  logic signed [32:0]        m_cabs;
  logic                      vd;
  logic                      d_inside;
  logic                      d_cpos;
  logic [31:0]               d_cm;
  logic [A_W-1:0]            d_a;
  logic signed [A_W-1:0]     d_h;
  logic signed [COORD_W-1:0] d_x1, d_y1, d_x2, d_y2;

  assign m_cabs = c_c[32] ? -c_c : c_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
    if (en) begin
      d_inside <= c_inside;
      d_cpos   <= !c_c[32] && (c_c != 33'sd0);
      d_cm     <= m_cabs[31:0];
      d_a      <= {1'b0, c_ddx} + {1'b0, c_ddy};
      d_h      <= c_hx + c_hy;
      d_x1     <= c_x1;
      d_y1     <= c_y1;
      d_x2     <= c_x2;
      d_y2     <= c_y2;
    end
  end

  // Stage E: h*h and a*|c|.
  logic signed [67:0]        m_hh;
  logic [65:0]               m_ac;
  logic                      ve;
  logic                      e_inside;
  logic                      e_cpos;
  logic [64:0]               e_hh, e_ac;
  logic [A_W-1:0]            e_a;
  logic signed [A_W-1:0]     e_h;
  logic signed [COORD_W-1:0] e_x1, e_y1, e_x2, e_y2;

  assign m_hh = d_h * d_h;
  assign m_ac = d_a * d_cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vd;
    end
    if (en) begin
      e_inside <= d_inside;
      e_cpos   <= d_cpos;
      e_hh     <= m_hh[64:0];
      e_ac     <= m_ac[64:0];
      e_a      <= d_a;
      e_h      <= d_h;
      e_x1     <= d_x1;
      e_y1     <= d_y1;
      e_x2     <= d_x2;
      e_y2     <= d_y2;
    end
  end

  // Stage F: E = h*h - a*c, with a negative value flagged.
  logic                      vf;
  logic                      f_inside;
  logic                      f_neg;
  logic [E_W-1:0]            f_e;
  logic [A_W-1:0]            f_a;
  logic signed [A_W-1:0]     f_h;
  logic signed [COORD_W-1:0] f_x1, f_y1, f_x2, f_y2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= ve;
    end
    if (en) begin
      f_inside <= e_inside;
      f_neg    <= e_cpos && (e_ac > e_hh);
      f_e      <= e_cpos ? ({1'b0, e_hh} - {1'b0, e_ac}) : ({1'b0, e_hh} + {1'b0, e_ac});
      f_a      <= e_a;
      f_h      <= e_h;
      f_x1     <= e_x1;
      f_y1     <= e_y1;
      f_x2     <= e_x2;
      f_y2     <= e_y2;
    end
  end

  // Stage G: graze test 4E <= tolerance (both in units of 2^-32), square root entry.
  logic sqv [0:SQ_BITS];
  sq_t  sq  [0:SQ_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else if (en) begin
      sqv[0] <= vf;
    end
    if (en) begin
      sq[0].encl   <= f_inside;
      sq[0].miss   <= f_neg || (f_a == '0) || ({f_e, 2'b00} <= TERM_W'(tol));
      sq[0].x1     <= f_x1;
      sq[0].y1     <= f_y1;
      sq[0].x2     <= f_x2;
      sq[0].y2     <= f_y2;
      sq[0].a      <= f_a;
      sq[0].h      <= f_h;
      sq[0].rem    <= f_e;
      sq[0].root   <= '0;
    end
  end

  // Square root: one result bit per stage, remainder kept as E - root^2.
  for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
    localparam int B = SQ_BITS - 1 - k;
    logic [TERM_W-1:0] term;
    sq_t               nxt;

    assign term = (TERM_W'(sq[k].root) << (B + 1)) + (TERM_W'(1) << (2 * B));

    always_comb begin
      nxt = sq[k];
      if (TERM_W'(sq[k].rem) >= term) begin
        nxt.rem     = sq[k].rem - term[E_W-1:0];
        nxt.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[k+1] <= 1'b0;
      end else if (en) begin
        sqv[k+1] <= sqv[k];
      end
      if (en) begin
        sq[k+1] <= nxt;
      end
    end
  end

  // Stage H: root interval numerators n1 = -h - S and n2 = -h + S.
  logic signed [35:0]        m_h36, m_s36, m_a36, m_n1, m_n2;
  logic                      vh;
  logic                      h_inside, h_miss;
  logic signed [35:0]        h_n1, h_n2;
  logic [A_W-1:0]            h_a;
  logic signed [COORD_W-1:0] h_x1, h_y1, h_x2, h_y2;

  assign m_h36 = 36'(sq[SQ_BITS].h);
  assign m_s36 = $signed(36'(sq[SQ_BITS].root));
  assign m_a36 = $signed(36'(sq[SQ_BITS].a));
  assign m_n1  = -m_h36 - m_s36;
  assign m_n2  = -m_h36 + m_s36;

  always_ff @(posedge clk) begin
    if (rst) begin
      vh <= 1'b0;
    end else if (en) begin
      vh <= sqv[SQ_BITS];
    end
    if (en) begin
      h_inside <= sq[SQ_BITS].encl;
      h_miss   <= sq[SQ_BITS].miss || (m_n1 > m_a36) || (m_n2 < 36'sd0);
      h_n1     <= m_n1;
      h_n2     <= m_n2;
      h_a      <= sq[SQ_BITS].a;
      h_x1     <= sq[SQ_BITS].x1;
      h_y1     <= sq[SQ_BITS].y1;
      h_x2     <= sq[SQ_BITS].x2;
      h_y2     <= sq[SQ_BITS].y2;
    end
  end

  // Stage I: clamp the numerators to [0, a]; the clamped ends land exactly on the endpoints.
  logic signed [35:0]        m_ha36;
  logic                      vi;
  logic                      i_inside, i_miss;
  logic [A_W-1:0]            i_n1c, i_n2c, i_a;
  logic signed [16:0]        i_dx, i_dy;
  logic signed [COORD_W-1:0] i_x1, i_y1, i_x2, i_y2;

  assign m_ha36 = $signed(36'(h_a));

  always_ff @(posedge clk) begin
    if (rst) begin
      vi <= 1'b0;
    end else if (en) begin
      vi <= vh;
    end
    if (en) begin
      i_inside <= h_inside;
      i_miss   <= h_miss;
      i_n1c    <= (h_n1 < 36'sd0) ? '0 : h_n1[A_W-1:0];
      i_n2c    <= (h_n2 > m_ha36) ? h_a : h_n2[A_W-1:0];
      i_a      <= h_a;
      i_dx     <= 17'(h_x2) - 17'(h_x1);
      i_dy     <= 17'(h_y2) - 17'(h_y1);
      i_x1     <= h_x1;
      i_y1     <= h_y1;
      i_x2     <= h_x2;
      i_y2     <= h_y2;
    end
  end

  // Stage J: products P1*a and d*n for both clipped points.
  logic signed [50:0]        m_pxa, m_pya;
  logic signed [51:0]        m_dxn1, m_dyn1, m_dxn2, m_dyn2;
  logic                      vj;
  logic                      j_inside, j_miss;
  logic signed [50:0]        j_pxa, j_pya;
  logic signed [51:0]        j_dxn1, j_dyn1, j_dxn2, j_dyn2;
  logic [A_W-1:0]            j_a;
  logic signed [COORD_W-1:0] j_x1, j_y1, j_x2, j_y2;

  assign m_pxa  = i_x1 * $signed({1'b0, i_a});
  assign m_pya  = i_y1 * $signed({1'b0, i_a});
  assign m_dxn1 = i_dx * $signed({1'b0, i_n1c});
  assign m_dyn1 = i_dy * $signed({1'b0, i_n1c});
  assign m_dxn2 = i_dx * $signed({1'b0, i_n2c});
  assign m_dyn2 = i_dy * $signed({1'b0, i_n2c});

  always_ff @(posedge clk) begin
    if (rst) begin
      vj <= 1'b0;
    end else if (en) begin
      vj <= vi;
    end
    if (en) begin
      j_inside <= i_inside;
      j_miss   <= i_miss;
      j_pxa    <= m_pxa;
      j_pya    <= m_pya;
      j_dxn1   <= m_dxn1;
      j_dyn1   <= m_dyn1;
      j_dxn2   <= m_dxn2;
      j_dyn2   <= m_dyn2;
      j_a      <= i_a;
      j_x1     <= i_x1;
      j_y1     <= i_y1;
      j_x2     <= i_x2;
      j_y2     <= i_y2;
    end
  end

  // Stage K: rounding numerators 2*(P1*a + d*n) + a, offset so the quotient is never negative.
  logic signed [55:0] m_aoff;
  logic signed [55:0] m_num [LANES];
  logic               dvv [0:DIV_BITS];
  dv_t                dv  [0:DIV_BITS];

  assign m_aoff   = $signed(56'(j_a)) + $signed(56'(j_a) << DIV_BITS);
  assign m_num[0] = ((56'(j_pxa) + 56'(j_dxn1)) <<< 1) + m_aoff;
  assign m_num[1] = ((56'(j_pya) + 56'(j_dyn1)) <<< 1) + m_aoff;
  assign m_num[2] = ((56'(j_pxa) + 56'(j_dxn2)) <<< 1) + m_aoff;
  assign m_num[3] = ((56'(j_pya) + 56'(j_dyn2)) <<< 1) + m_aoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (en) begin
      dvv[0] <= vj;
    end
    if (en) begin
      dv[0].encl   <= j_inside;
      dv[0].miss   <= j_miss;
      dv[0].x1     <= j_x1;
      dv[0].y1     <= j_y1;
      dv[0].x2     <= j_x2;
      dv[0].y2     <= j_y2;
      dv[0].den    <= {j_a, 1'b0};
      for (int l = 0; l < LANES; l++) begin
        dv[0].rem[l] <= m_num[l][NUM_W-1:0];
      end
      dv[0].quo    <= '0;
    end
  end

  // Divider: one quotient bit per stage in each of the four lanes, shared divisor 2a.
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    localparam int B = DIV_BITS - 1 - k;
    logic [NUM_W-1:0] dsh;
    dv_t              nxt;

    assign dsh = NUM_W'(dv[k].den) << B;

    always_comb begin
      nxt = dv[k];
      for (int l = 0; l < LANES; l++) begin
        if (dv[k].rem[l] >= dsh) begin
          nxt.rem[l]    = dv[k].rem[l] - dsh;
          nxt.quo[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (en) begin
        dvv[k+1] <= dvv[k];
      end
      if (en) begin
        dv[k+1] <= nxt;
      end
    end
  end

  // Output register: endpoints when inside, zeros on a miss, else the rounded quotients.
  // The low bits of the offset quotient are the signed result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvv[DIV_BITS];
    end
    if (en) begin
      if (dv[DIV_BITS].encl) begin
        inside_hit   <= 1'b1;
        clip_start_x <= dv[DIV_BITS].x1;
        clip_start_y <= dv[DIV_BITS].y1;
        clip_end_x   <= dv[DIV_BITS].x2;
        clip_end_y   <= dv[DIV_BITS].y2;
      end else if (dv[DIV_BITS].miss) begin
        inside_hit   <= 1'b0;
        clip_start_x <= '0;
        clip_start_y <= '0;
        clip_end_x   <= '0;
        clip_end_y   <= '0;
      end else begin
        inside_hit   <= 1'b1;
        clip_start_x <= $signed(dv[DIV_BITS].quo[0][COORD_W-1:0]);
        clip_start_y <= $signed(dv[DIV_BITS].quo[1][COORD_W-1:0]);
        clip_end_x   <= $signed(dv[DIV_BITS].quo[2][COORD_W-1:0]);
        clip_end_y   <= $signed(dv[DIV_BITS].quo[3][COORD_W-1:0]);
      end
    end
  end

endmodule

`default_nettype wire

### sv/scc_check.sv
// Port-level checker of the segment circle clipper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scc_check import scc_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic                      inside_hit,
  input wire logic signed [COORD_W-1:0] clip_start_x,
  input wire logic signed [COORD_W-1:0] clip_start_y,
  input wire logic signed [COORD_W-1:0] clip_end_x,
  input wire logic signed [COORD_W-1:0] clip_end_y
);

  // A held result keeps its valid and payload.
  `SCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(inside_hit) && $stable(clip_start_x) && $stable(clip_start_y) && $stable(clip_end_x) && $stable(clip_end_y), "held result changed")

  // A held result stalls the input side.
  `SCC_ASSERT(a_stall_back, out_valid && out_stall |-> in_stall, "input taken while output held")

  // With no result waiting the block takes requests.
  `SCC_ASSERT(a_idle_ready, !out_valid |-> !in_stall, "input stalled with output empty")

  // A miss reports a zero segment.
  `SCC_ASSERT(a_miss_zero, out_valid && !inside_hit |-> clip_start_x == 0 && clip_start_y == 0 && clip_end_x == 0 && clip_end_y == 0, "miss with nonzero points")

endmodule

bind segment_circle_clip_top scc_check u_scc_check (.*);

`default_nettype wire
